// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl
// expects signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define IFR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while in reset
`define IFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ifr_pkg.sv -----
// types and constants of the image frame receiver
// no dependencies
package ifr_pkg;

   localparam logic [7:0]  SYNC_BYTE       = 8'hB7;
   localparam logic [7:0]  TYPE_IMAGE      = 8'h01;
   localparam logic        OP_BYTE         = 1'b0;
   localparam logic        OP_TICK         = 1'b1;
   localparam logic        KIND_PIXEL      = 1'b0;
   localparam logic        KIND_TIMEOUT    = 1'b1;
   localparam int          CSR_W           = 16;
   localparam int          CSR_IDX_W       = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ID = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 1'd1;
   localparam logic [7:0]  DEVICE_ID_RESET = 8'd1;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd10000;
   localparam logic [15:0] TICK_MAX        = 16'hFFFF;
   localparam logic [1:0]  SUB_LAST        = 2'd2;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  pixel_index;
      logic [23:0] pixel_color;
      logic [5:0]  byte_count;
      logic        last;
   } rsp_type;

endpackage

// ----- hw/rtl/ifr_stream_if.sv -----
// valid/ready stream channel carrying one word of payload_type
// no dependencies; payload types come from ifr_pkg at instantiation
interface ifr_stream_if #(
   parameter type payload_type = logic [7:0]
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/image_frame_receiver.sv -----
// image frame receiver: sync/target/type parser, payload store, pixel walk
// depends on ifr_pkg, ifr_stream_if and assert_macros.svh
//
//  channel   dir  carries
//  req_chan  in   ifr_pkg::req_type  (opcode, rx_byte): one byte or one tick per word
//  rsp_chan  out  ifr_pkg::rsp_type  (kind, pixel_index, pixel_color, byte_count, last)
//  csr_*     in   write enable, register index, 16-bit data; no read-back
//
// while parsing, each byte or tick word is taken as it comes; the word that follows waits
//   until any pending result word has been taken
// a good checksum byte starts a walk over the payload memory: for each pixel, three
//   read and take pairs through the single registered read port, then a send state
//   that holds the pixel until rsp_chan.ready takes it
// reset is synchronous and active high; the payload memory is not cleared
// no input word is taken while the pixel walk runs or a result word waits
`include "assert_macros.svh"

module image_frame_receiver #(
   parameter int PIXELS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   ifr_stream_if.sink                    req_chan,
   ifr_stream_if.source                  rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [ifr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ifr_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int PAYLOAD_LEN = PIXELS * 3;
   localparam int ADDR_W      = $clog2(PAYLOAD_LEN);
   localparam int CNT_W       = $clog2(PAYLOAD_LEN + 1);
   localparam int PIX_W       = (PIXELS > 1) ? $clog2(PIXELS) : 1;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_TARGET,
      ST_TYPE,
      ST_PAYLOAD,
      ST_CHECK,
      ST_READ,
      ST_TAKE,
      ST_SEND
   } state_type;

   state_type               state_ff, state_in;
   logic [7:0]              device_id_ff;
   logic [15:0]             timeout_ff;
   logic [CNT_W-1:0]        byte_index_ff, byte_index_in;
   logic [7:0]              sum_ff, sum_in;
   logic [15:0]             tick_ff, tick_in;
   logic [ADDR_W-1:0]       rd_addr_ff, rd_addr_in;
   logic [1:0]              sub_ff, sub_in;
   logic [PIX_W-1:0]        pix_ff, pix_in;
   logic [23:0]             color_ff, color_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ifr_pkg::rsp_type        rsp_ff, rsp_in;

   // payload store, one write and one registered read per cycle
   logic [7:0]              payload_mem [PAYLOAD_LEN];
   logic [7:0]              rd_data_ff;
   logic                    mem_we;

   ifr_pkg::req_type        req_word;
   logic                    req_ready;
   logic                    accept;
   logic                    last_pix;
   logic [CNT_W+5:0]        count_wide;
   logic [PIX_W+3:0]        pix_wide;

   assign req_word  = req_chan.payload;
   // parse states take a word only once the output register is free
   assign req_ready = (state_ff inside {ST_HUNT, ST_TARGET, ST_TYPE, ST_PAYLOAD, ST_CHECK})
                      && !rsp_valid_ff;
   assign req_chan.ready = req_ready;
   assign accept    = req_chan.valid && req_ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign last_pix   = (pix_ff == PIX_W'(PIXELS - 1));
   // result fields are masked to their port widths
   assign count_wide = {6'd0, byte_index_ff};
   assign pix_wide   = {4'd0, pix_ff};

   always_comb begin
      state_in      = state_ff;
      byte_index_in = byte_index_ff;
      sum_in        = sum_ff;
      tick_in       = tick_ff;
      rd_addr_in    = rd_addr_ff;
      sub_in        = sub_ff;
      pix_in        = pix_ff;
      color_in      = color_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      mem_we        = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_HUNT, ST_TARGET, ST_TYPE, ST_PAYLOAD, ST_CHECK: begin
            if (accept && req_word.opcode == ifr_pkg::OP_TICK) begin
               // ticks only count while the payload is coming in
               if (state_ff == ST_PAYLOAD) begin
                  tick_in = (tick_ff == ifr_pkg::TICK_MAX) ? tick_ff : tick_ff + 16'd1;
                  if (tick_in >= timeout_ff) begin
                     rsp_in.kind        = ifr_pkg::KIND_TIMEOUT;
                     rsp_in.pixel_index = 4'd0;
                     rsp_in.pixel_color = 24'd0;
                     rsp_in.byte_count  = count_wide[5:0];
                     rsp_in.last        = 1'b1;
                     rsp_valid_in       = 1'b1;
                     state_in           = ST_HUNT;
                  end
               end
            end else if (accept) begin
               case (state_ff)
                  ST_HUNT: begin
                     if (req_word.rx_byte == ifr_pkg::SYNC_BYTE) begin
                        state_in = ST_TARGET;
                     end
                  end
                  ST_TARGET: begin
                     state_in = (req_word.rx_byte == device_id_ff) ? ST_TYPE : ST_HUNT;
                  end
                  ST_TYPE: begin
                     if (req_word.rx_byte == ifr_pkg::TYPE_IMAGE) begin
                        state_in      = ST_PAYLOAD;
                        byte_index_in = '0;
                        sum_in        = 8'd0;
                        tick_in       = 16'd0;
                     end else begin
                        state_in = ST_HUNT;
                     end
                  end
                  ST_PAYLOAD: begin
                     mem_we        = 1'b1;
                     sum_in        = sum_ff + req_word.rx_byte;
                     byte_index_in = byte_index_ff + 1'b1;
                     if (byte_index_in == CNT_W'(PAYLOAD_LEN)) begin
                        state_in = ST_CHECK;
                     end
                  end
                  default: begin
                     // checksum byte: good sum starts the pixel walk, bad sum drops
                     if (req_word.rx_byte == sum_ff) begin
                        state_in   = ST_READ;
                        rd_addr_in = '0;
                        sub_in     = 2'd0;
                        pix_in     = '0;
                     end else begin
                        state_in = ST_HUNT;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            // address is stable this cycle, data lands in rd_data_ff
            state_in = ST_TAKE;
         end
         ST_TAKE: begin
            color_in   = {color_ff[15:0], rd_data_ff};
            rd_addr_in = rd_addr_ff + 1'b1;
            if (sub_ff == ifr_pkg::SUB_LAST) begin
               sub_in             = 2'd0;
               rsp_in.kind        = ifr_pkg::KIND_PIXEL;
               rsp_in.pixel_index = pix_wide[3:0];
               rsp_in.pixel_color = color_in;
               rsp_in.byte_count  = 6'd0;
               rsp_in.last        = last_pix;
               rsp_valid_in       = 1'b1;
               state_in           = ST_SEND;
            end else begin
               sub_in   = sub_ff + 2'd1;
               state_in = ST_READ;
            end
         end
         ST_SEND: begin
            if (rsp_chan.ready) begin
               if (last_pix) begin
                  state_in = ST_HUNT;
               end else begin
                  pix_in   = pix_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_HUNT;
         device_id_ff  <= ifr_pkg::DEVICE_ID_RESET;
         timeout_ff    <= ifr_pkg::TIMEOUT_RESET;
         byte_index_ff <= '0;
         sum_ff        <= 8'd0;
         tick_ff       <= 16'd0;
         rd_addr_ff    <= '0;
         sub_ff        <= 2'd0;
         pix_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         byte_index_ff <= byte_index_in;
         sum_ff        <= sum_in;
         tick_ff       <= tick_in;
         rd_addr_ff    <= rd_addr_in;
         sub_ff        <= sub_in;
         pix_ff        <= pix_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               ifr_pkg::CSR_DEVICE_ID: device_id_ff <= csr_wdata[7:0];
               ifr_pkg::CSR_TIMEOUT:   timeout_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      color_ff <= color_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         payload_mem[byte_index_ff[ADDR_W-1:0]] <= req_word.rx_byte;
      end
      rd_data_ff <= payload_mem[rd_addr_ff];
   end

   // a finished pixel always reaches the output register
   `IFR_ASSERT_NEXT(a_take_loads, (state_ff == ST_TAKE) && (sub_ff == ifr_pkg::SUB_LAST), rsp_valid_ff, "pixel not loaded into output")
   // while a pixel waits for the sink it stays valid
   `IFR_ASSERT_IMPL(a_send_valid, state_ff == ST_SEND, rsp_valid_ff, "send state without valid word")
   // a timeout error is always the only, hence last, result
   `IFR_ASSERT_IMPL(a_err_last, rsp_valid_ff && (rsp_ff.kind == ifr_pkg::KIND_TIMEOUT), rsp_ff.last && (state_ff != ST_SEND), "timeout word not marked last")

endmodule

// ----- sim/image_frame_receiver_tb.sv -----
// self-checking bench for image_frame_receiver: a scripted run of words, then random frames
// every result word is checked against this bench's frame parser or a typed script row
// depends on ifr_pkg, ifr_stream_if and image_frame_receiver from the rtl
module image_frame_receiver_tb;

   localparam int PIXELS        = 16;
   localparam int PAY_LEN       = PIXELS * 3;
   localparam int SETTLE_CYCLES = 16;    // ample margin for the block to settle
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int STALL_LIMIT   = 3000;  // cycles with no word moving on either channel
   localparam int RAND_WORDS    = 190;
   localparam int PHASE_WORDS   = 50;

   // parser phases, mirroring the block's frame walk
   typedef enum logic [2:0] {
      SEEK_SYNC, WANT_TARGET, WANT_TYPE, TAKE_PAYLOAD, WANT_SUM
   } frame_phase_type;
   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_RAMP} fill_mode_type;
   typedef enum {ROW_WORD, ROW_CSR} row_op_type;

   // one line of the scripted run
   typedef struct {
      row_op_type                     op;
      ifr_pkg::req_type               w;
      logic [ifr_pkg::CSR_IDX_W-1:0]  idx;
      logic [ifr_pkg::CSR_W-1:0]      data;
      bit                             typed;   // result written out by hand below
      ifr_pkg::rsp_type               rsp;
   } script_row_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_wr_en;
   logic [ifr_pkg::CSR_IDX_W-1:0] csr_index;
   logic [ifr_pkg::CSR_W-1:0]     csr_wdata;

   ifr_stream_if #(.payload_type(ifr_pkg::req_type)) req_chan ();
   ifr_stream_if #(.payload_type(ifr_pkg::rsp_type)) rsp_chan ();

   image_frame_receiver #(.PIXELS(PIXELS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // parser state and register copies
   frame_phase_type frame_phase;
   int              pay_count;
   logic [7:0]      pay_sum;
   logic [15:0]     ticks_seen;
   logic [7:0]      pay_mem [PAY_LEN];
   logic [7:0]      cfg_device_id;
   logic [15:0]     cfg_timeout;

   ifr_pkg::rsp_type frame_results_due [$];   // result words still owed by the block
   script_row_type   script [$];

   int mismatch_count;
   int rand_words;       // words accepted, reset after the script
   bit req_gaps_on;
   bit rsp_gaps_on;
   bit hold_rsp;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // work out what one accepted word makes the block emit
   task automatic parse_word(input ifr_pkg::req_type w, input bit keep);
      ifr_pkg::rsp_type r;
      int               i;
      r = '0;
      if (w.opcode == ifr_pkg::OP_TICK) begin
         // ticks only matter while the payload is coming in
         if (frame_phase == TAKE_PAYLOAD) begin
            if (ticks_seen != ifr_pkg::TICK_MAX) ticks_seen = ticks_seen + 16'd1;
            if (ticks_seen >= cfg_timeout) begin
               r.kind       = ifr_pkg::KIND_TIMEOUT;
               r.byte_count = 6'(pay_count);
               r.last       = 1'b1;
               if (keep) frame_results_due.push_back(r);
               frame_phase = SEEK_SYNC;
            end
         end
      end else begin
         case (frame_phase)
            SEEK_SYNC: begin
               if (w.rx_byte == ifr_pkg::SYNC_BYTE) frame_phase = WANT_TARGET;
            end
            WANT_TARGET: begin
               // a rejected byte is used up, never looked at again as a sync byte
               frame_phase = (w.rx_byte == cfg_device_id) ? WANT_TYPE : SEEK_SYNC;
            end
            WANT_TYPE: begin
               if (w.rx_byte == ifr_pkg::TYPE_IMAGE) begin
                  frame_phase = TAKE_PAYLOAD;
                  pay_count   = 0;
                  pay_sum     = '0;
                  ticks_seen  = '0;
               end else begin
                  frame_phase = SEEK_SYNC;
               end
            end
            TAKE_PAYLOAD: begin
               pay_mem[pay_count] = w.rx_byte;
               pay_sum            = pay_sum + w.rx_byte;
               pay_count++;
               if (pay_count >= PAY_LEN) frame_phase = WANT_SUM;
            end
            WANT_SUM: begin
               // no timeout here; a bad sum drops the frame quietly
               frame_phase = SEEK_SYNC;
               if (w.rx_byte == pay_sum) begin
                  for (i = 0; i < PIXELS; i++) begin
                     r             = '0;
                     r.kind        = ifr_pkg::KIND_PIXEL;
                     r.pixel_index = 4'(i);
                     r.pixel_color = {pay_mem[3*i], pay_mem[3*i+1], pay_mem[3*i+2]};
                     r.last        = (i == PIXELS - 1);
                     if (keep) frame_results_due.push_back(r);
                  end
               end
            end
            default: frame_phase = SEEK_SYNC;
         endcase
      end
   endtask

   // offer one word, with a random gap in front, and wait for it to be taken
   task automatic send_word(input ifr_pkg::req_type w, input bit typed,
                            input ifr_pkg::rsp_type typed_rsp);
      int gap;
      gap = (req_gaps_on && $urandom_range(0, 99) < 30) ? $urandom_range(1, 3) : 0;
      if (gap != 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.payload <= w;
      do @(posedge clock); while (!req_chan.ready);
      parse_word(w, !typed);
      if (typed) frame_results_due.push_back(typed_rsp);
      rand_words++;
   endtask

   task automatic put_byte(input logic [7:0] b);
      send_word('{opcode: ifr_pkg::OP_BYTE, rx_byte: b}, 1'b0, '0);
   endtask

   task automatic put_tick();
      send_word('{opcode: ifr_pkg::OP_TICK, rx_byte: 8'($urandom_range(0, 255))}, 1'b0, '0);
   endtask

   // register write: sender parked, every owed word collected, block settled first
   task automatic write_reg(input logic [ifr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ifr_pkg::CSR_W-1:0] data);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == ifr_pkg::CSR_DEVICE_ID) cfg_device_id = data[7:0];
      else if (idx == ifr_pkg::CSR_TIMEOUT) cfg_timeout = data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // sync, target, type, payload and then either the checksum or ticks
   // cut below PAY_LEN leaves the payload short; its ticks time out only if cfg_timeout <= 24
   task automatic send_frame(input fill_mode_type fill, input bit sum_ok, input int tick_pct,
                             input int cut);
      logic [7:0] sum;
      logic [7:0] b;
      int         k;
      sum = '0;
      put_byte(ifr_pkg::SYNC_BYTE);
      put_byte(cfg_device_id);
      put_byte(ifr_pkg::TYPE_IMAGE);
      for (k = 0; k < cut; k++) begin
         if ($urandom_range(0, 99) < tick_pct) put_tick();
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            FILL_RAMP: b = 8'(k * 5 + 1);
            default:   b = 8'($urandom_range(0, 255));
         endcase
         put_byte(b);
         sum = sum + b;
      end
      if (cut == PAY_LEN) begin
         // ticks while the checksum is awaited must not time out
         if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 3)) put_tick();
         put_byte(sum_ok ? sum : sum ^ 8'($urandom_range(1, 255)));
      end else begin
         repeat ((cfg_timeout <= 24) ? int'(cfg_timeout) : 3) put_tick();
      end
   endtask

   // script helpers
   function automatic void add_word(input logic op, input logic [7:0] b);
      script.push_back('{ROW_WORD, '{opcode: op, rx_byte: b}, '0, '0, 1'b0, '0});
   endfunction

   function automatic void add_csr(input logic [ifr_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [ifr_pkg::CSR_W-1:0] d);
      script.push_back('{ROW_CSR, '0, idx, d, 1'b0, '0});
   endfunction

   // tick that must end the payload with a timeout word carrying n
   function automatic void add_timeout(input logic [5:0] n);
      script.push_back('{ROW_WORD, '{opcode: ifr_pkg::OP_TICK, rx_byte: 8'h00}, '0, '0, 1'b1,
                         '{kind: ifr_pkg::KIND_TIMEOUT, pixel_index: 4'd0, pixel_color: 24'd0,
                           byte_count: n, last: 1'b1}});
   endfunction

   // receiver: random ready, plus one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_chan.ready <= !(rsp_gaps_on && $urandom_range(0, 99) < 37);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      ifr_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (frame_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word: kind=%0d idx=%0d color=%06h count=%0d last=%0d",
                        rsp_chan.payload.kind, rsp_chan.payload.pixel_index,
                        rsp_chan.payload.pixel_color, rsp_chan.payload.byte_count,
                        rsp_chan.payload.last);
         end else begin
            want = frame_results_due.pop_front();
            if (rsp_chan.payload.kind !== want.kind ||
                rsp_chan.payload.pixel_index !== want.pixel_index ||
                rsp_chan.payload.pixel_color !== want.pixel_color ||
                rsp_chan.payload.byte_count !== want.byte_count ||
                rsp_chan.payload.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: want kind=%0d idx=%0d color=%06h count=%0d last=%0d",
                           want.kind, want.pixel_index, want.pixel_color, want.byte_count,
                           want.last,
                           ", got kind=%0d idx=%0d color=%06h count=%0d last=%0d",
                           rsp_chan.payload.kind, rsp_chan.payload.pixel_index,
                           rsp_chan.payload.pixel_color, rsp_chan.payload.byte_count,
                           rsp_chan.payload.last);
            end
         end
      end
   end

   // watchdog: too long with no word moving on either side
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   // stimulus
   initial begin
      int          pick;
      int          phase_no;
      int          phase_start;
      int          tick_pct;
      bit          held_once;
      logic [7:0]  b;
      logic [7:0]  new_id;
      logic [15:0] new_timeout;

      // every input known from time zero
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      mismatch_count   = 0;
      rand_words       = 0;
      req_gaps_on      = 1'b1;
      rsp_gaps_on      = 1'b1;
      hold_rsp         = 1'b0;
      held_once        = 1'b0;

      // parser state after reset
      frame_phase   = SEEK_SYNC;
      pay_count     = 0;
      pay_sum       = '0;
      ticks_seen    = '0;
      cfg_device_id = ifr_pkg::DEVICE_ID_RESET;
      cfg_timeout   = ifr_pkg::TIMEOUT_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // scripted run
      add_word(ifr_pkg::OP_TICK, 8'hFF);            // tick while hunting, ignored
      add_word(ifr_pkg::OP_BYTE, 8'h00);
      add_word(ifr_pkg::OP_BYTE, 8'hFF);
      add_csr(ifr_pkg::CSR_TIMEOUT, 16'd1);         // shortest timeout
      add_word(ifr_pkg::OP_TICK, 8'h00);
      add_word(ifr_pkg::OP_BYTE, ifr_pkg::SYNC_BYTE);
      add_word(ifr_pkg::OP_BYTE, ifr_pkg::SYNC_BYTE);   // wrong target, used up
      add_word(ifr_pkg::OP_BYTE, 8'h01);            // would be a match if resynced on the last byte
      add_word(ifr_pkg::OP_BYTE, ifr_pkg::TYPE_IMAGE);
      add_word(ifr_pkg::OP_TICK, 8'h00);            // so nothing comes out here
      add_word(ifr_pkg::OP_BYTE, ifr_pkg::SYNC_BYTE);
      add_word(ifr_pkg::OP_BYTE, 8'h01);
      add_word(ifr_pkg::OP_BYTE, 8'h02);            // unknown type, back to hunting
      add_word(ifr_pkg::OP_TICK, 8'h00);
      add_word(ifr_pkg::OP_BYTE, ifr_pkg::SYNC_BYTE);
      add_word(ifr_pkg::OP_BYTE, 8'h01);
      add_word(ifr_pkg::OP_BYTE, ifr_pkg::TYPE_IMAGE);
      add_timeout(6'd0);                            // timeout with an empty payload
      add_word(ifr_pkg::OP_TICK, 8'h00);            // back to hunting, ignored
      add_csr(ifr_pkg::CSR_DEVICE_ID, 16'h00FF);
      add_word(ifr_pkg::OP_BYTE, ifr_pkg::SYNC_BYTE);
      add_word(ifr_pkg::OP_BYTE, 8'hFF);
      add_word(ifr_pkg::OP_BYTE, ifr_pkg::TYPE_IMAGE);
      add_word(ifr_pkg::OP_BYTE, 8'h80);
      add_timeout(6'd1);
      add_csr(ifr_pkg::CSR_DEVICE_ID, 16'h0000);
      add_csr(ifr_pkg::CSR_TIMEOUT, 16'd5);
      add_word(ifr_pkg::OP_BYTE, ifr_pkg::SYNC_BYTE);
      add_word(ifr_pkg::OP_BYTE, 8'h00);
      add_word(ifr_pkg::OP_BYTE, ifr_pkg::TYPE_IMAGE);
      add_word(ifr_pkg::OP_BYTE, 8'h7F);
      add_word(ifr_pkg::OP_TICK, 8'h00);
      add_word(ifr_pkg::OP_TICK, 8'h00);
      add_csr(ifr_pkg::CSR_TIMEOUT, 16'd3);         // lowered mid-frame, applies at once
      add_timeout(6'd1);

      foreach (script[i]) begin
         if (script[i].op == ROW_CSR)
            write_reg(script[i].idx, script[i].data);
         else
            send_word(script[i].w, script[i].typed, script[i].rsp);
      end

      // random part, in phases of register settings
      rand_words = 0;
      phase_no   = 0;
      while (rand_words < RAND_WORDS) begin
         case (phase_no)
            0:       begin new_id = 8'h5A;              new_timeout = 16'hFFFF; end
            1:       begin new_id = ifr_pkg::SYNC_BYTE; new_timeout = 16'd6;    end
            2:       begin new_id = 8'h00;              new_timeout = 16'd1;    end
            3:       begin new_id = 8'hFF;              new_timeout = 16'd30;   end
            default: begin
               new_id      = 8'($urandom_range(0, 255));
               new_timeout = 16'($urandom_range(1, 64));
            end
         endcase
         // both registers written with the sender parked and nothing owed
         write_reg(ifr_pkg::CSR_DEVICE_ID, {8'h00, new_id});
         write_reg(ifr_pkg::CSR_TIMEOUT, new_timeout);

         // one phase runs flat out on both sides
         req_gaps_on = (phase_no != 1);
         rsp_gaps_on = (phase_no != 1);

         phase_start = rand_words;
         while (rand_words - phase_start < PHASE_WORDS && rand_words < RAND_WORDS) begin
            pick     = $urandom_range(0, 99);
            tick_pct = ($urandom_range(0, 9) < 7) ? 0 : 4;
            if (!held_once) begin
               // receiver stalls while the pixel walk runs, so the input backs up
               held_once = 1'b1;
               hold_rsp  = 1'b1;
               send_frame(FILL_RANDOM, 1'b1, 0, PAY_LEN);
               repeat (6) put_byte(8'($urandom_range(0, 255)));
            end else if (pick < 60) begin
               send_frame(fill_mode_type'($urandom_range(0, 3)), $urandom_range(0, 4) != 0,
                          tick_pct, PAY_LEN);
            end else if (pick < 72) begin
               send_frame(fill_mode_type'($urandom_range(0, 3)), 1'b1, 0,
                          $urandom_range(0, PAY_LEN - 1));
            end else if (pick < 88) begin
               // broken headers
               case ($urandom_range(0, 2))
                  0: begin
                     put_byte(ifr_pkg::SYNC_BYTE);
                     put_byte(cfg_device_id ^ 8'($urandom_range(1, 255)));
                  end
                  1: begin
                     put_byte(ifr_pkg::SYNC_BYTE);
                     put_byte(cfg_device_id);
                     put_byte(ifr_pkg::TYPE_IMAGE ^ 8'($urandom_range(1, 255)));
                  end
                  default: begin
                     put_byte(ifr_pkg::SYNC_BYTE);
                     put_tick();
                     put_byte(ifr_pkg::SYNC_BYTE);
                  end
               endcase
            end else begin
               // line noise, sync bytes more often than chance
               repeat ($urandom_range(1, 6)) begin
                  b = ($urandom_range(0, 3) == 0) ? ifr_pkg::SYNC_BYTE
                                                  : 8'($urandom_range(0, 255));
                  if ($urandom_range(0, 1) == 1) put_tick();
                  else put_byte(b);
               end
            end
         end
         phase_no++;
      end

      // drain and let the block settle
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
